// ===== rtl/keepalive_timeout_table_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef KEEPALIVE_TIMEOUT_TABLE_MACROS_SVH
`define KEEPALIVE_TIMEOUT_TABLE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define KT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define KT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/kt_pkg.sv =====
package kt_pkg;

    localparam int SLOTS_DEF     = 8;
    localparam int MAX_REPORTS   = 8;
    localparam int WS_BITS       = 8;
    localparam int DEFAULT_DELAY = 30000;
    localparam int OVERDUE_DELAY = 1000;
    localparam int CHECK_RST     = 10000;
    localparam int TIMEOUT_RST   = 30000;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_TOUCH  = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_SWEEP  = 3'd3,
        CMD_QUERY  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        K_OK          = 3'd0,
        K_NO_SPACE    = 3'd1,
        K_NOT_FOUND   = 3'd2,
        K_PING        = 3'd3,
        K_CLOSE       = 3'd4,
        K_FORGOTTEN   = 3'd5,
        K_NOTHING_DUE = 3'd6,
        K_NEXT_CHECK  = 3'd7
    } t_kind;

    typedef enum logic {
        REG_CHECK_PERIOD = 1'b0,
        REG_INACT_TIMEOUT = 1'b1
    } t_reg;

    // Queued command with precomputed time bases (now - period, now - timeout).
    typedef struct packed {
        t_cmd               cmd;
        logic [15:0]        conn_id;
        logic [47:0]        now_ms;
        logic [7:0]         ws;
        logic signed [49:0] base_chk;
        logic signed [49:0] base_to;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  slot;
        logic [15:0] conn_id;
        logic [14:0] delay_ms;
        logic        last;
    } t_res;

endpackage

// ===== rtl/keepalive_timeout_table.sv =====
// Keepalive slot table. Each command walks the SLOTS slots in index order,
// reading each slot from the slot memory and then evaluating it; add stops at
// the first free slot, touch and remove at the first match, and a sweep after
// MAX_REPORTS reports. A two-entry command queue in front takes items while a
// scan runs; a sweep holds back one report so the final beat carries last, and
// a stalled output stretches it. Commands 5..7 are accepted and give no result.
module keepalive_timeout_table
    import kt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_conn_id,
    input  logic [47:0] i_now_ms,
    input  logic [7:0]  i_websocket_slots,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [2:0]  o_slot,
    output logic [15:0] o_out_conn_id,
    output logic [14:0] o_delay_ms,
    output logic        o_last
);

    t_head head;
    logic  pop;
    t_res  res;

    kt_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_conn_id         (i_conn_id),
        .i_now_ms          (i_now_ms),
        .i_websocket_slots (i_websocket_slots),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_head            (head),
        .i_pop             (pop)
    );

    kt_back #(.SLOTS(SLOTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res)
    );

    assign o_kind        = res.kind;
    assign o_slot        = res.slot;
    assign o_out_conn_id = res.conn_id;
    assign o_delay_ms    = res.delay_ms;
    assign o_last        = res.last;

endmodule

// ===== rtl/kt_front.sv =====
module kt_front
    import kt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_conn_id,
    input  logic [47:0] i_now_ms,
    input  logic [7:0]  i_websocket_slots,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    output t_head       o_head,
    input  logic        i_pop
);

    logic [23:0] r_check;
    logic [23:0] r_timeout;
    t_item       r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        push;
    logic        known;
    t_item       w_item;

    assign o_in_stall = (r_cnt == 2'd2);
    // cmd 5..7 is accepted and dropped here
    assign known = (i_cmd <= 3'(CMD_QUERY));
    assign push  = i_in_valid && !o_in_stall && known;

    always_comb begin
        w_item.cmd      = t_cmd'(i_cmd);
        w_item.conn_id  = i_conn_id;
        w_item.now_ms   = i_now_ms;
        w_item.ws       = i_websocket_slots;
        w_item.base_chk = $signed({2'b0, i_now_ms}) - $signed({26'b0, r_check});
        w_item.base_to  = $signed({2'b0, i_now_ms}) - $signed({26'b0, r_timeout});
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_check   <= 24'(CHECK_RST);
            r_timeout <= 24'(TIMEOUT_RST);
            r_wp      <= 1'b0;
            r_rp      <= 1'b0;
            r_cnt     <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_idx))
                    REG_CHECK_PERIOD:  r_check   <= i_cfg_data;
                    REG_INACT_TIMEOUT: r_timeout <= i_cfg_data;
                    default: ;
                endcase
            end
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

// ===== rtl/kt_back.sv =====
module kt_back
    import kt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_head i_head,
    output logic  o_pop,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    output t_res  o_res
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_EVAL  = 4'b0100,
        ST_FLUSH = 4'b1000
    } t_state;

    t_state      r_state;
    t_item       r_item;
    logic [IW-1:0] r_idx;
    logic [3:0]  r_n;
    logic [14:0] r_delay;
    t_res        r_pend;
    logic        r_pend_v;
    t_res        r_out;
    logic        r_out_v;
    logic [SLOTS-1:0] r_active;

    logic [15:0] r_mem_conn [SLOTS];
    logic [47:0] r_mem_seen [SLOTS];
    logic [15:0] r_rd_conn;
    logic [47:0] r_rd_seen;

    logic               act;
    logic               match;
    logic               last_idx;
    logic               ws_bit;
    logic signed [49:0] diff_chk;
    logic signed [49:0] diff_to;
    logic               due;
    logic               late;
    logic               sooner;
    logic [14:0]        n_delay;
    logic               out_free;
    logic               out_load;
    logic               n_final;
    t_res               hit_res;

    assign o_pop       = i_head.valid && (r_state == ST_IDLE);
    assign o_out_valid = r_out_v;
    assign o_res       = r_out;
    assign out_free    = !r_out_v || !i_out_stall;

    always_comb begin
        act      = r_active[r_idx];
        match    = act && (r_rd_conn == r_item.conn_id);
        last_idx = (r_idx == IW'(SLOTS - 1));
        ws_bit   = (int'(r_idx) < WS_BITS) ? r_item.ws[3'(r_idx)] : 1'b0;
        // seen + period <= now  <=>  seen - (now - period) <= 0
        diff_chk = $signed({2'b0, r_rd_seen}) - r_item.base_chk;
        diff_to  = $signed({2'b0, r_rd_seen}) - r_item.base_to;
        due      = diff_chk[49] || (diff_chk == '0);
        late     = diff_to[49] || (diff_to == '0);
        sooner   = diff_chk < $signed({35'b0, r_delay});
        n_delay  = r_delay;
        if (act && sooner) begin
            n_delay = diff_chk[49] ? 15'(OVERDUE_DELAY) : diff_chk[14:0];
        end
        n_final          = last_idx || (r_n == 4'(MAX_REPORTS - 1));
        hit_res.kind     = !ws_bit ? K_FORGOTTEN : (late ? K_CLOSE : K_PING);
        hit_res.slot     = 3'(r_idx);
        hit_res.conn_id  = r_rd_conn;
        hit_res.delay_ms = '0;
        hit_res.last     = n_final;
        // output register takes a beat: flush, or a held sweep report pushed out by a new hit
        out_load = out_free && ((r_state == ST_FLUSH) ||
                   ((r_state == ST_EVAL) && (r_item.cmd == CMD_SWEEP) && act && due && r_pend_v));
    end

    // slot memory: one read port at the scan index, one write port
    always_ff @(posedge i_clk) begin
        r_rd_conn <= r_mem_conn[r_idx];
        r_rd_seen <= r_mem_seen[r_idx];
        if (r_state == ST_EVAL) begin
            if (r_item.cmd == CMD_ADD && !act) begin
                r_mem_conn[r_idx] <= r_item.conn_id;
                r_mem_seen[r_idx] <= r_item.now_ms;
            end else if (r_item.cmd == CMD_TOUCH && match) begin
                r_mem_seen[r_idx] <= r_item.now_ms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
            r_active <= '0;
            r_idx    <= '0;
        end else begin
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_head.valid) begin
                        r_item   <= i_head.item;
                        r_idx    <= '0;
                        r_n      <= '0;
                        r_pend_v <= 1'b0;
                        r_delay  <= 15'(DEFAULT_DELAY);
                        r_state  <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_EVAL;
                end
                ST_EVAL: begin
                    case (r_item.cmd)
                        CMD_ADD: begin
                            if (!act) begin
                                r_active[r_idx] <= 1'b1;
                                r_pend  <= '{K_OK, 3'(r_idx), r_item.conn_id, 15'd0, 1'b1};
                                r_state <= ST_FLUSH;
                            end else if (last_idx) begin
                                r_pend  <= '{K_NO_SPACE, 3'd0, r_item.conn_id, 15'd0, 1'b1};
                                r_state <= ST_FLUSH;
                            end else begin
                                r_idx   <= r_idx + 1'b1;
                                r_state <= ST_READ;
                            end
                        end
                        CMD_TOUCH, CMD_REMOVE: begin
                            if (match) begin
                                if (r_item.cmd == CMD_REMOVE) begin
                                    r_active[r_idx] <= 1'b0;
                                end
                                r_pend  <= '{K_OK, 3'(r_idx), r_item.conn_id, 15'd0, 1'b1};
                                r_state <= ST_FLUSH;
                            end else if (last_idx) begin
                                r_pend <= '{(r_item.cmd == CMD_TOUCH) ? K_NOT_FOUND : K_OK,
                                            3'd0, r_item.conn_id, 15'd0, 1'b1};
                                r_state <= ST_FLUSH;
                            end else begin
                                r_idx   <= r_idx + 1'b1;
                                r_state <= ST_READ;
                            end
                        end
                        CMD_SWEEP: begin
                            if (act && due) begin
                                // one held beat, so the final one can carry last
                                if (!r_pend_v || out_free) begin
                                    if (r_pend_v) begin
                                        r_out <= r_pend;
                                    end
                                    r_pend   <= hit_res;
                                    r_pend_v <= 1'b1;
                                    r_n      <= r_n + 1'b1;
                                    if (!ws_bit) begin
                                        r_active[r_idx] <= 1'b0;
                                    end
                                    if (n_final) begin
                                        r_state <= ST_FLUSH;
                                    end else begin
                                        r_idx   <= r_idx + 1'b1;
                                        r_state <= ST_READ;
                                    end
                                end
                            end else if (last_idx) begin
                                if (r_pend_v) begin
                                    r_pend.last <= 1'b1;
                                end else begin
                                    r_pend <= '{K_NOTHING_DUE, 3'd0, 16'd0, 15'd0, 1'b1};
                                end
                                r_state <= ST_FLUSH;
                            end else begin
                                r_idx   <= r_idx + 1'b1;
                                r_state <= ST_READ;
                            end
                        end
                        CMD_QUERY: begin
                            r_delay <= n_delay;
                            if (last_idx) begin
                                r_pend  <= '{K_NEXT_CHECK, 3'd0, 16'd0, n_delay, 1'b1};
                                r_state <= ST_FLUSH;
                            end else begin
                                r_idx   <= r_idx + 1'b1;
                                r_state <= ST_READ;
                            end
                        end
                        default: r_state <= ST_IDLE;
                    endcase
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        r_out    <= r_pend;
                        r_pend_v <= 1'b0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/kt_checker.sv =====
`include "keepalive_timeout_table_macros.svh"

module kt_checker
    import kt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_kind,
    input logic [2:0]  o_slot,
    input logic [15:0] o_out_conn_id,
    input logic [14:0] o_delay_ms,
    input logic        o_last
);

    `KT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable({o_kind, o_slot, o_out_conn_id, o_delay_ms, o_last}), "stalled beat changed")
    `KT_ASSERT_NOW(a_single, i_clk, i_rst_n, o_out_valid && (o_kind == 3'(K_NEXT_CHECK) || o_kind == 3'(K_NOTHING_DUE) || o_kind == 3'(K_NO_SPACE) || o_kind == 3'(K_NOT_FOUND)), o_last && o_slot == 3'd0, "single-beat result malformed")
    `KT_ASSERT_NOW(a_delay0, i_clk, i_rst_n, o_out_valid && o_kind != 3'(K_NEXT_CHECK), o_delay_ms == 15'd0, "delay outside next_check")
    `KT_ASSERT_NOW(a_delay_max, i_clk, i_rst_n, o_out_valid && o_kind == 3'(K_NEXT_CHECK), o_delay_ms <= 15'(DEFAULT_DELAY) && o_out_conn_id == 16'd0, "next_check out of range")

endmodule

bind keepalive_timeout_table kt_checker u_kt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_kind        (o_kind),
    .o_slot        (o_slot),
    .o_out_conn_id (o_out_conn_id),
    .o_delay_ms    (o_delay_ms),
    .o_last        (o_last)
);
